/* sv/tld_pkg.sv */
package tld_pkg;

    // Depth of the receive ring.
    localparam int BUFFER_DEPTH = 256;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = PTR_W + 1;
    localparam int WANT_W       = 9;
    localparam int RDY_W        = (CNT_W > WANT_W) ? CNT_W : WANT_W;
    localparam int SAT_W        = (CNT_W > 8) ? CNT_W : 8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_SIGNAL   = 2'd1;
    localparam logic [1:0] CFG_EDIT     = 2'd2;
    localparam logic [1:0] CFG_RAW_MIN  = 2'd3;

    localparam logic [4:0]  MODE_RESET    = 5'd31;
    localparam logic [23:0] SIGNAL_RESET  = 24'h1A1C03;
    localparam logic [39:0] EDIT_RESET    = 40'h4157F;
    localparam logic [7:0]  RAW_MIN_RESET = 8'd1;

    // Mode flag bit positions.
    localparam int MODE_ISIG   = 0;
    localparam int MODE_CANON  = 1;
    localparam int MODE_ECHO   = 2;
    localparam int MODE_ICRNL  = 3;
    localparam int MODE_ONLCR  = 4;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_DEL = 8'h7F;

    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic [1:0] SIG_NONE    = 2'd0;
    localparam logic [1:0] SIG_INTR    = 2'd1;
    localparam logic [1:0] SIG_QUIT    = 2'd2;
    localparam logic [1:0] SIG_SUSPEND = 2'd3;

    // Canonical edit class of a received character.
    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_EOF   = 2'd1;
    localparam logic [1:0] CLS_ERASE = 2'd2;
    localparam logic [1:0] CLS_KILL  = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        ch;
        logic [1:0]        sig;
        logic [1:0]        cls;
        logic              eol;
        logic [WANT_W-1:0] wanted;
    } t_op;

    typedef struct packed {
        logic [CNT_W-1:0] fill;
        logic             rec;
        logic             eof;
    } t_ring_status;

endpackage

/* sv/tld_ram.sv */
module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tld_front.sv */
module tld_front import tld_pkg::*; (
    input  logic              i_command,
    input  logic [7:0]        i_rx_byte,
    input  logic [WANT_W-1:0] i_wanted_count,
    input  logic [4:0]        i_mode,
    input  logic [23:0]       i_signal_chars,
    input  logic [39:0]       i_edit_chars,
    output t_op               o_op
);

    function automatic logic f_match(input logic [7:0] cc, input logic [7:0] ch);
        return (cc != 8'd0) && (cc == ch);
    endfunction

    logic [7:0] ch;

    always_comb begin
        // Signal characters are matched on the byte before CR translation.
        ch = (i_mode[MODE_ICRNL] && (i_rx_byte == CH_CR)) ? CH_NL : i_rx_byte;

        o_op.cmd    = i_command;
        o_op.ch     = ch;
        o_op.wanted = i_wanted_count;

        o_op.sig = SIG_NONE;
        if (i_mode[MODE_ISIG]) begin
            if (f_match(i_signal_chars[7:0], i_rx_byte)) begin
                o_op.sig = SIG_INTR;
            end else if (f_match(i_signal_chars[15:8], i_rx_byte)) begin
                o_op.sig = SIG_QUIT;
            end else if (f_match(i_signal_chars[23:16], i_rx_byte)) begin
                o_op.sig = SIG_SUSPEND;
            end
        end

        if (f_match(i_edit_chars[23:16], ch)) begin
            o_op.cls = CLS_EOF;
        end else if (f_match(i_edit_chars[7:0], ch) || (ch == CH_BS) || (ch == CH_DEL)) begin
            o_op.cls = CLS_ERASE;
        end else if (f_match(i_edit_chars[15:8], ch)) begin
            o_op.cls = CLS_KILL;
        end else begin
            o_op.cls = CLS_OTHER;
        end

        o_op.eol = (ch == CH_NL) || f_match(i_edit_chars[31:24], ch)
                   || f_match(i_edit_chars[39:32], ch);
    end

endmodule

/* sv/tld_queue.sv */
module tld_queue import tld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_op  i_push,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_op  o_pop
);

    t_op        r_entry [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop        = r_entry[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* sv/tld_back.sv */
module tld_back import tld_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [4:0]   i_mode,
    input  logic [7:0]   i_raw_min,
    input  logic         i_op_valid,
    output logic         o_op_ready,
    input  t_op          i_op,
    input  logic         i_out_ready,
    output logic         o_out_valid,
    output logic         o_accepted,
    output logic         o_echo_valid,
    output logic         o_echo_cr_first,
    output logic [7:0]   o_echo_byte,
    output logic [7:0]   o_erase_echo_count,
    output logic [1:0]   o_signal_code,
    output logic         o_read_valid,
    output logic [7:0]   o_read_byte,
    output logic         o_read_eof,
    output logic         o_readable,
    output logic         o_line_ready,
    output logic         o_eof_pending,
    output t_ring_status o_status
);

    function automatic logic f_readable(
        input logic              eof,
        input logic              rec,
        input logic              canon,
        input logic [CNT_W-1:0]  fill,
        input logic [7:0]        vmin_raw,
        input logic [WANT_W-1:0] count
    );
        logic [RDY_W-1:0] vmin;
        logic [RDY_W-1:0] cnt;
        logic [RDY_W-1:0] lim;
        vmin = (vmin_raw == 8'd0) ? RDY_W'(1) : RDY_W'(vmin_raw);
        cnt  = (count == '0) ? RDY_W'(1) : RDY_W'(count);
        lim  = (vmin > cnt) ? cnt : vmin;
        return eof || (canon ? (rec && (fill != '0)) : (RDY_W'(fill) >= lim));
    endfunction

    // Ring state.
    logic [CNT_W-1:0] r_fill;
    logic [PTR_W-1:0] r_rptr;
    logic             r_rec;
    logic             r_eof;
    logic [CNT_W-1:0] n_fill;
    logic [PTR_W-1:0] n_rptr;
    logic             n_rec;
    logic             n_eof;

    // Result register.
    logic       r_out_valid;
    logic       r_accepted;
    logic       r_echo_valid;
    logic       r_echo_cr;
    logic [7:0] r_echo_byte;
    logic [7:0] r_erase;
    logic [1:0] r_sig;
    logic       r_read_valid;
    logic       r_read_eof;
    logic       r_readable;
    logic       n_accepted;
    logic       n_echo_valid;
    logic       n_echo_cr;
    logic [7:0] n_echo_byte;
    logic [7:0] n_erase;
    logic [1:0] n_sig;
    logic       n_read_valid;
    logic       n_read_eof;
    logic       n_readable;

    logic             exec_go;
    logic             canon;
    logic             echo;
    logic             blocked;
    logic             store;
    logic             ram_we;
    logic             ram_re;
    logic [CNT_W-1:0] pos_sum;
    logic [PTR_W-1:0] wpos;
    logic [CNT_W-1:0] rptr_inc;
    logic [SAT_W-1:0] fill_ext;
    logic [7:0]       fill_sat;
    logic [7:0]       ram_rdata;

    assign o_op_ready = !r_out_valid || i_out_ready;
    assign exec_go    = i_op_valid && o_op_ready;
    assign canon      = i_mode[MODE_CANON];
    assign echo       = i_mode[MODE_ECHO];

    always_comb begin
        pos_sum  = CNT_W'(r_rptr) + r_fill;
        wpos     = (pos_sum >= CNT_W'(BUFFER_DEPTH)) ? PTR_W'(pos_sum - CNT_W'(BUFFER_DEPTH))
                                                     : PTR_W'(pos_sum);
        rptr_inc = CNT_W'(r_rptr) + CNT_W'(1);
        fill_ext = SAT_W'(r_fill);
        fill_sat = (fill_ext > SAT_W'(255)) ? 8'hFF : fill_ext[7:0];

        n_fill       = r_fill;
        n_rptr       = r_rptr;
        n_rec        = r_rec;
        n_eof        = r_eof;
        n_accepted   = 1'b0;
        n_echo_valid = 1'b0;
        n_echo_cr    = 1'b0;
        n_echo_byte  = 8'd0;
        n_erase      = 8'd0;
        n_sig        = SIG_NONE;
        n_read_valid = 1'b0;
        n_read_eof   = 1'b0;
        store        = 1'b0;
        ram_re       = 1'b0;
        blocked      = canon ? (r_rec || r_eof) : (r_fill >= CNT_W'(BUFFER_DEPTH));

        if (i_op.cmd == CMD_RECEIVE) begin
            if (!blocked) begin
                n_accepted = 1'b1;
                n_sig      = i_op.sig;
                if (i_op.sig != SIG_NONE) begin
                    n_rptr = '0;
                    n_fill = '0;
                    n_rec  = 1'b0;
                    n_eof  = 1'b0;
                end else if (canon) begin
                    case (i_op.cls)
                        CLS_EOF: begin
                            if (r_fill == '0) begin
                                n_eof = 1'b1;
                            end else begin
                                n_rec = 1'b1;
                            end
                        end
                        CLS_ERASE: begin
                            if (r_fill != '0) begin
                                n_fill = r_fill - CNT_W'(1);
                                n_erase = echo ? 8'd1 : 8'd0;
                            end
                        end
                        CLS_KILL: begin
                            n_erase = echo ? fill_sat : 8'd0;
                            n_fill  = '0;
                        end
                        default: begin
                            // One slot is kept free so that a line can always be closed.
                            store = r_fill < CNT_W'(BUFFER_DEPTH - 1);
                            if (i_op.eol) begin
                                n_rec = 1'b1;
                            end
                        end
                    endcase
                end else begin
                    store = 1'b1;
                end
                if (store) begin
                    n_fill = r_fill + CNT_W'(1);
                    if (echo) begin
                        n_echo_valid = 1'b1;
                        n_echo_byte  = i_op.ch;
                        n_echo_cr    = (i_op.ch == CH_NL) && i_mode[MODE_ONLCR];
                    end
                end
            end
        end else if ((i_op.wanted != '0)
                     && f_readable(r_eof, r_rec, canon, r_fill, i_raw_min, i_op.wanted)) begin
            if (r_fill != '0) begin
                n_read_valid = 1'b1;
                ram_re       = 1'b1;
                n_fill       = r_fill - CNT_W'(1);
                n_rptr       = (rptr_inc >= CNT_W'(BUFFER_DEPTH)) ? '0 : PTR_W'(rptr_inc);
                if (r_fill == CNT_W'(1)) begin
                    n_rptr = '0;
                    n_rec  = 1'b0;
                end
            end else if (r_eof) begin
                n_eof      = 1'b0;
                n_read_eof = 1'b1;
            end
        end

        n_readable = f_readable(n_eof, n_rec, canon, n_fill, i_raw_min, i_op.wanted);
        ram_we     = exec_go && store;
    end

    // The read data register only moves on a read, so it holds while the result stalls.
    tld_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wpos),
        .i_wdata (i_op.ch),
        .i_re    (exec_go && ram_re),
        .i_raddr (r_rptr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rptr      <= '0;
            r_rec       <= 1'b0;
            r_eof       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec_go) begin
                r_fill      <= n_fill;
                r_rptr      <= n_rptr;
                r_rec       <= n_rec;
                r_eof       <= n_eof;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_accepted   <= n_accepted;
            r_echo_valid <= n_echo_valid;
            r_echo_cr    <= n_echo_cr;
            r_echo_byte  <= n_echo_byte;
            r_erase      <= n_erase;
            r_sig        <= n_sig;
            r_read_valid <= n_read_valid;
            r_read_eof   <= n_read_eof;
            r_readable   <= n_readable;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_accepted         = r_accepted;
    assign o_echo_valid       = r_echo_valid;
    assign o_echo_cr_first    = r_echo_cr;
    assign o_echo_byte        = r_echo_byte;
    assign o_erase_echo_count = r_erase;
    assign o_signal_code      = r_sig;
    assign o_read_valid       = r_read_valid;
    assign o_read_byte        = r_read_valid ? ram_rdata : 8'd0;
    assign o_read_eof         = r_read_eof;
    assign o_readable         = r_readable;
    assign o_line_ready       = r_rec;
    assign o_eof_pending      = r_eof;
    assign o_status.fill      = r_fill;
    assign o_status.rec       = r_rec;
    assign o_status.eof       = r_eof;

endmodule

/* sv/tty_line_discipline.sv */
// Terminal receive line discipline. Each input transaction either delivers one byte from
// the line (command 0) or asks to read one byte out (command 1), and yields exactly one
// result transaction carrying echo, erase count, signal, read data and status flags.
// The block sustains one transaction per clock while the output is not stalled: the front end
// classifies the byte against the signal and edit characters, a two-entry queue decouples it
// from the back end, and the back end updates the ring and fills the output register. A result
// is held first in a queue entry and then in the output register, and the registered read
// of the ring RAM lands together with the output register. A stalled output holds the back end,
// and once both queue entries are full the input stalls as well.
// No clearing pass is needed after reset; the ring is usable at once.
// Configuration registers may only be written while no transaction is in flight.
module tty_line_discipline import tld_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [39:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [7:0]        i_rx_byte,
    input  logic [WANT_W-1:0] i_wanted_count,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_accepted,
    output logic              o_echo_valid,
    output logic              o_echo_cr_first,
    output logic [7:0]        o_echo_byte,
    output logic [7:0]        o_erase_echo_count,
    output logic [1:0]        o_signal_code,
    output logic              o_read_valid,
    output logic [7:0]        o_read_byte,
    output logic              o_read_eof,
    output logic              o_readable,
    output logic              o_line_ready,
    output logic              o_eof_pending
);

    logic [4:0]   r_mode;
    logic [23:0]  r_signal_chars;
    logic [39:0]  r_edit_chars;
    logic [7:0]   r_raw_min;

    t_op          front_op;
    t_op          queue_op;
    logic         queue_valid;
    logic         back_ready;
    t_ring_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_RESET;
            r_signal_chars <= SIGNAL_RESET;
            r_edit_chars   <= EDIT_RESET;
            r_raw_min      <= RAW_MIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:    r_mode         <= i_cfg_data[4:0];
                CFG_SIGNAL:  r_signal_chars <= i_cfg_data[23:0];
                CFG_EDIT:    r_edit_chars   <= i_cfg_data;
                CFG_RAW_MIN: r_raw_min      <= i_cfg_data[7:0];
                default:     r_mode         <= r_mode;
            endcase
        end
    end

    tld_front u_front (
        .i_command      (i_command),
        .i_rx_byte      (i_rx_byte),
        .i_wanted_count (i_wanted_count),
        .i_mode         (r_mode),
        .i_signal_chars (r_signal_chars),
        .i_edit_chars   (r_edit_chars),
        .o_op           (front_op)
    );

    tld_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in_valid),
        .o_push_ready (o_in_ready),
        .i_push       (front_op),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (back_ready),
        .o_pop        (queue_op)
    );

    tld_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_mode             (r_mode),
        .i_raw_min          (r_raw_min),
        .i_op_valid         (queue_valid),
        .o_op_ready         (back_ready),
        .i_op               (queue_op),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_accepted         (o_accepted),
        .o_echo_valid       (o_echo_valid),
        .o_echo_cr_first    (o_echo_cr_first),
        .o_echo_byte        (o_echo_byte),
        .o_erase_echo_count (o_erase_echo_count),
        .o_signal_code      (o_signal_code),
        .o_read_valid       (o_read_valid),
        .o_read_byte        (o_read_byte),
        .o_read_eof         (o_read_eof),
        .o_readable         (o_readable),
        .o_line_ready       (o_line_ready),
        .o_eof_pending      (o_eof_pending),
        .o_status           (status)
    );

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.fill <= CNT_W'(BUFFER_DEPTH))
        else $error("ring fill count beyond buffer depth");

    a_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_read_valid && o_read_eof) && !(o_accepted && o_read_valid))
        else $error("result carries conflicting read and receive outcomes");

    a_eof_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_eof) |-> !o_eof_pending)
        else $error("end-of-file reported but mark still set");

    a_canon_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_mode[MODE_CANON] && o_echo_valid) |-> o_accepted)
        else $error("echo produced for a refused byte");
`endif

endmodule

/* test/tty_line_discipline_test.sv */
module tty_line_discipline_test;
    import tld_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 230;
    localparam int DIR_ROWS    = 23;

    typedef struct packed {
        logic       accepted;
        logic       echo_valid;
        logic       echo_cr;
        logic [7:0] echo_byte;
        logic [7:0] erase_cnt;
        logic [1:0] sig;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_eof;
        logic       readable;
        logic       line_ready;
        logic       eof_pending;
    } t_disc_result;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        rx;
        logic [WANT_W-1:0] wanted;
        logic              fixed;
        t_disc_result      res;
    } t_steer_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE,
        STALL_LIGHT
    } t_stall_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [39:0]       i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_command;
    logic [7:0]        i_rx_byte;
    logic [WANT_W-1:0] i_wanted_count;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_accepted;
    logic              o_echo_valid;
    logic              o_echo_cr_first;
    logic [7:0]        o_echo_byte;
    logic [7:0]        o_erase_echo_count;
    logic [1:0]        o_signal_code;
    logic              o_read_valid;
    logic [7:0]        o_read_byte;
    logic              o_read_eof;
    logic              o_readable;
    logic              o_line_ready;
    logic              o_eof_pending;

    // Shadow copy of the block's registers and ring.
    logic [4:0]  mode_q  = MODE_RESET;
    logic [23:0] sig_q   = SIGNAL_RESET;
    logic [39:0] edit_q  = EDIT_RESET;
    logic [7:0]  min_q   = RAW_MIN_RESET;
    logic [7:0]  ring_mem [BUFFER_DEPTH];
    int unsigned ring_head = 0;
    int unsigned ring_fill = 0;
    logic        line_done = 1'b0;
    logic        eof_seen  = 1'b0;

    t_disc_result due_results [$];
    t_disc_result oldest;
    t_steer_row   dir_rows [DIR_ROWS];
    int           fail_count  = 0;
    int           cycle_count = 0;
    int           burst_left  = 0;
    int           phase_items = 0;
    bit           hold_request = 1'b0;

    tty_line_discipline i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_rx_byte          (i_rx_byte),
        .i_wanted_count     (i_wanted_count),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_accepted         (o_accepted),
        .o_echo_valid       (o_echo_valid),
        .o_echo_cr_first    (o_echo_cr_first),
        .o_echo_byte        (o_echo_byte),
        .o_erase_echo_count (o_erase_echo_count),
        .o_signal_code      (o_signal_code),
        .o_read_valid       (o_read_valid),
        .o_read_byte        (o_read_byte),
        .o_read_eof         (o_read_eof),
        .o_readable         (o_readable),
        .o_line_ready       (o_line_ready),
        .o_eof_pending      (o_eof_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic edit_hit(int idx, logic [7:0] ch);
        logic [7:0] cc;
        cc = edit_q[8*idx +: 8];
        return cc != 8'd0 && cc == ch;
    endfunction

    function automatic logic [1:0] signal_of(logic [7:0] b);
        if (!mode_q[MODE_ISIG])
            return SIG_NONE;
        if (sig_q[7:0] != 8'd0 && sig_q[7:0] == b)
            return SIG_INTR;
        if (sig_q[15:8] != 8'd0 && sig_q[15:8] == b)
            return SIG_QUIT;
        if (sig_q[23:16] != 8'd0 && sig_q[23:16] == b)
            return SIG_SUSPEND;
        return SIG_NONE;
    endfunction

    // A zero count is read as one; in raw mode the minimum is capped by the count.
    function automatic logic can_read(logic [WANT_W-1:0] count);
        int unsigned need;
        int unsigned cnt;
        if (eof_seen)
            return 1'b1;
        if (mode_q[MODE_CANON])
            return line_done && ring_fill > 0;
        need = (min_q == 8'd0) ? 1 : min_q;
        cnt = (count == '0) ? 1 : count;
        if (need > cnt)
            need = cnt;
        return ring_fill >= need;
    endfunction

    function automatic t_disc_result discipline_step(logic cmd, logic [7:0] rx,
                                                     logic [WANT_W-1:0] wanted);
        t_disc_result r;
        logic         canon;
        logic         echo_on;
        logic         blocked;
        logic         keep;
        logic [1:0]   sig;
        logic [7:0]   ch;
        r = '0;
        canon = mode_q[MODE_CANON];
        echo_on = mode_q[MODE_ECHO];
        if (cmd == CMD_RECEIVE) begin
            blocked = canon ? (line_done || eof_seen) : (ring_fill >= BUFFER_DEPTH);
            if (!blocked) begin
                r.accepted = 1'b1;
                sig = signal_of(rx);
                r.sig = sig;
                if (sig != SIG_NONE) begin
                    ring_head = 0;
                    ring_fill = 0;
                    line_done = 1'b0;
                    eof_seen = 1'b0;
                end else begin
                    ch = (mode_q[MODE_ICRNL] && rx == CH_CR) ? CH_NL : rx;
                    keep = 1'b0;
                    if (canon) begin
                        if (edit_hit(2, ch)) begin
                            if (ring_fill == 0)
                                eof_seen = 1'b1;
                            else
                                line_done = 1'b1;
                        end else if (edit_hit(0, ch) || ch == CH_BS || ch == CH_DEL) begin
                            if (ring_fill > 0) begin
                                ring_fill--;
                                if (echo_on)
                                    r.erase_cnt = 8'd1;
                            end
                        end else if (edit_hit(1, ch)) begin
                            if (echo_on)
                                r.erase_cnt = (ring_fill > 255) ? 8'd255 : 8'(ring_fill);
                            ring_fill = 0;
                        end else begin
                            // The last slot stays free, but a dropped closer still ends the line.
                            keep = ring_fill + 1 < BUFFER_DEPTH;
                            if (ch == CH_NL || edit_hit(3, ch) || edit_hit(4, ch))
                                line_done = 1'b1;
                        end
                    end else begin
                        keep = 1'b1;
                    end
                    if (keep) begin
                        ring_mem[(ring_head + ring_fill) % BUFFER_DEPTH] = ch;
                        ring_fill++;
                        if (echo_on) begin
                            r.echo_valid = 1'b1;
                            r.echo_byte = ch;
                            r.echo_cr = ch == CH_NL && mode_q[MODE_ONLCR];
                        end
                    end
                end
            end
        end else if (wanted != '0 && can_read(wanted)) begin
            if (ring_fill > 0) begin
                r.read_valid = 1'b1;
                r.read_byte = ring_mem[ring_head];
                ring_head = (ring_head + 1) % BUFFER_DEPTH;
                ring_fill--;
                if (ring_fill == 0) begin
                    ring_head = 0;
                    line_done = 1'b0;
                end
            end else if (eof_seen) begin
                eof_seen = 1'b0;
                r.read_eof = 1'b1;
            end
        end
        r.readable = can_read(wanted);
        r.line_ready = line_done;
        r.eof_pending = eof_seen;
        return r;
    endfunction

    function automatic t_disc_result known_result(logic acc, logic [1:0] sig, logic reof,
                                                  logic rdy, logic line, logic eofp);
        t_disc_result r;
        r = '0;
        r.accepted = acc;
        r.sig = sig;
        r.read_eof = reof;
        r.readable = rdy;
        r.line_ready = line;
        r.eof_pending = eofp;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                $error("result transaction with no input transaction outstanding");
                fail_count++;
            end else begin
                oldest = due_results.pop_front();
                check_field("accepted", 8'(oldest.accepted), 8'(o_accepted));
                check_field("echo_valid", 8'(oldest.echo_valid), 8'(o_echo_valid));
                check_field("echo_cr_first", 8'(oldest.echo_cr), 8'(o_echo_cr_first));
                check_field("echo_byte", oldest.echo_byte, o_echo_byte);
                check_field("erase_echo_count", oldest.erase_cnt, o_erase_echo_count);
                check_field("signal_code", 8'(oldest.sig), 8'(o_signal_code));
                check_field("read_valid", 8'(oldest.read_valid), 8'(o_read_valid));
                check_field("read_byte", oldest.read_byte, o_read_byte);
                check_field("read_eof", 8'(oldest.read_eof), 8'(o_read_eof));
                check_field("readable", 8'(oldest.readable), 8'(o_readable));
                check_field("line_ready", 8'(oldest.line_ready), 8'(o_line_ready));
                check_field("eof_pending", 8'(oldest.eof_pending), 8'(o_eof_pending));
            end
        end
    end

    // Output side: stall patterns that change every so often, plus one long hold-off.
    initial begin : receiver
        int          slot_left;
        int          tick;
        t_stall_mode stall;
        slot_left = 0;
        tick = 0;
        stall = STALL_NONE;
        i_out_ready = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            if (slot_left == 0) begin
                stall = t_stall_mode'($urandom_range(0, 3));
                slot_left = $urandom_range(20, 150);
            end
            slot_left--;
            tick++;
            case (stall)
                STALL_NONE:   i_out_ready <= 1'b1;
                STALL_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                STALL_SPARSE: i_out_ready <= (tick % 4 == 0);
                default:      i_out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Offers one transaction, with a random gap between bursts, and records what it
    // should produce once the block has taken it.
    task automatic send(logic cmd, logic [7:0] rx, logic [WANT_W-1:0] wanted,
                        logic fixed, t_disc_result known);
        t_disc_result predicted;
        int           gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_rx_byte <= rx;
        i_wanted_count <= wanted;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        predicted = discipline_step(cmd, rx, wanted);
        due_results.push_back(fixed ? known : predicted);
        phase_items++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [1:0] idx, logic [39:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [4:0] mode, logic [23:0] sigs, logic [39:0] edits,
                             logic [7:0] min_cnt);
        put_reg(CFG_MODE, 40'(mode));
        put_reg(CFG_SIGNAL, 40'(sigs));
        put_reg(CFG_EDIT, edits);
        put_reg(CFG_RAW_MIN, 40'(min_cnt));
        i_cfg_we <= 1'b0;
        mode_q = mode;
        sig_q = sigs;
        edit_q = edits;
        min_q = min_cnt;
    endtask

    function automatic logic [WANT_W-1:0] rand_wanted();
        case ($urandom_range(0, 19))
            0:       return '0;
            1, 2:    return 9'd256;
            default: return 9'($urandom_range(1, 255));
        endcase
    endfunction

    // Mostly printable text with a sprinkling of editing and signal characters.
    function automatic logic [7:0] content_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return CH_BS;
        if (r < 4)
            return CH_DEL;
        if (r < 6)
            return edit_q[7:0];
        if (r < 8)
            return edit_q[15:8];
        if (r < 9)
            return sig_q[8*$urandom_range(0, 2) +: 8];
        if (r < 14)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    function automatic logic [7:0] closer_byte();
        case ($urandom_range(0, 6))
            0:       return CH_NL;
            1:       return CH_CR;
            2:       return edit_q[23:16];
            3:       return edit_q[31:24];
            4:       return edit_q[39:32];
            5:       return 8'($urandom_range(0, 255));
            default: return CH_NL;
        endcase
    endfunction

    task automatic drain_reads();
        int guard;
        logic [WANT_W-1:0] w;
        guard = 0;
        while (can_read(9'd1) && guard < 300) begin
            w = ($urandom_range(0, 3) == 0) ? rand_wanted() : 9'd1;
            send(CMD_READ, 8'($urandom_range(0, 255)), w, 1'b0, '0);
            guard++;
        end
    endtask

    task automatic canonical_line();
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(240, 270) : $urandom_range(0, 24);
        repeat (len)
            send(CMD_RECEIVE, content_byte(), rand_wanted(), 1'b0, '0);
        send(CMD_RECEIVE, closer_byte(), rand_wanted(), 1'b0, '0);
        drain_reads();
    endtask

    task automatic raw_burst();
        int n;
        int read_pct;
        n = ($urandom_range(0, 14) == 0) ? $urandom_range(250, 275) : $urandom_range(1, 40);
        read_pct = (n > 200) ? 0 : $urandom_range(0, 50);
        repeat (n) begin
            if ($urandom_range(0, 99) < read_pct)
                send(CMD_READ, 8'($urandom_range(0, 255)), rand_wanted(), 1'b0, '0);
            else if ($urandom_range(0, 4) == 0)
                send(CMD_RECEIVE, content_byte(), rand_wanted(), 1'b0, '0);
            else
                send(CMD_RECEIVE, 8'($urandom_range(0, 255)), rand_wanted(), 1'b0, '0);
        end
        drain_reads();
    endtask

    task automatic line_noise();
        repeat ($urandom_range(5, 15))
            send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), rand_wanted(),
                 1'b0, '0);
    endtask

    initial begin : stimulus
        int p;
        int choice;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_MODE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = CMD_RECEIVE;
        i_rx_byte = 8'd0;
        i_wanted_count = 9'd1;

        // Directed rows run under the reset settings.
        dir_rows[0]  = '{CMD_READ,    8'h00, 9'd1,   1'b1, known_result(0, SIG_NONE, 0, 0, 0, 0)};
        dir_rows[1]  = '{CMD_READ,    8'hFF, 9'd0,   1'b1, known_result(0, SIG_NONE, 0, 0, 0, 0)};
        dir_rows[2]  = '{CMD_RECEIVE, 8'h04, 9'd1,   1'b1, known_result(1, SIG_NONE, 0, 1, 0, 1)};
        dir_rows[3]  = '{CMD_RECEIVE, 8'h61, 9'd1,   1'b1, known_result(0, SIG_NONE, 0, 1, 0, 1)};
        dir_rows[4]  = '{CMD_READ,    8'h00, 9'd0,   1'b1, known_result(0, SIG_NONE, 0, 1, 0, 1)};
        dir_rows[5]  = '{CMD_READ,    8'h00, 9'd256, 1'b1, known_result(0, SIG_NONE, 1, 0, 0, 0)};
        dir_rows[6]  = '{CMD_RECEIVE, 8'h03, 9'd1,   1'b1, known_result(1, SIG_INTR, 0, 0, 0, 0)};
        dir_rows[7]  = '{CMD_RECEIVE, 8'h1C, 9'd1,   1'b1, known_result(1, SIG_QUIT, 0, 0, 0, 0)};
        dir_rows[8]  = '{CMD_RECEIVE, 8'h1A, 9'd1,   1'b1,
                         known_result(1, SIG_SUSPEND, 0, 0, 0, 0)};
        dir_rows[9]  = '{CMD_RECEIVE, 8'h68, 9'd1,   1'b0, '0};
        dir_rows[10] = '{CMD_RECEIVE, 8'hFF, 9'd1,   1'b0, '0};
        dir_rows[11] = '{CMD_RECEIVE, CH_BS, 9'd1,   1'b0, '0};
        dir_rows[12] = '{CMD_RECEIVE, CH_DEL, 9'd1,  1'b0, '0};
        dir_rows[13] = '{CMD_RECEIVE, CH_DEL, 9'd1,  1'b0, '0};
        dir_rows[14] = '{CMD_RECEIVE, 8'h78, 9'd1,   1'b0, '0};
        dir_rows[15] = '{CMD_RECEIVE, 8'h79, 9'd1,   1'b0, '0};
        dir_rows[16] = '{CMD_RECEIVE, 8'h15, 9'd1,   1'b0, '0};
        dir_rows[17] = '{CMD_RECEIVE, 8'h7A, 9'd1,   1'b0, '0};
        dir_rows[18] = '{CMD_RECEIVE, CH_CR, 9'd1,   1'b0, '0};
        dir_rows[19] = '{CMD_RECEIVE, 8'h00, 9'd1,   1'b1, known_result(0, SIG_NONE, 0, 1, 1, 0)};
        dir_rows[20] = '{CMD_READ,    8'h00, 9'd255, 1'b0, '0};
        dir_rows[21] = '{CMD_READ,    8'hAA, 9'd256, 1'b0, '0};
        dir_rows[22] = '{CMD_READ,    8'h00, 9'd1,   1'b1, known_result(0, SIG_NONE, 0, 0, 0, 0)};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++)
            send(dir_rows[k].cmd, dir_rows[k].rx, dir_rows[k].wanted, dir_rows[k].fixed,
                 dir_rows[k].res);

        for (p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: configure(MODE_RESET, SIGNAL_RESET, EDIT_RESET, RAW_MIN_RESET);
                1: configure(5'h02, 24'h000000, EDIT_RESET, 8'd1);
                2: configure(5'h1D, SIGNAL_RESET, EDIT_RESET, 8'd4);
                3: configure(5'h00, 24'hFFFFFF, 40'hFF_FFFF_FFFF, 8'd255);
                4: configure(5'h1F, 24'h000000, 40'h00_0000_0000, 8'd0);
                5: configure(5'h06, 24'hFFFFFF, 40'hFF_FFFF_FFFF, 8'd0);
                6: configure(5'h0C, 24'h000000, 40'h00_0000_0000, 8'd0);
                default:
                    configure(5'($urandom_range(0, 31)),
                              {8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)),
                               8'($urandom_range(0, 31))},
                              {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)),
                               8'($urandom_range(0, 127))},
                              8'($urandom_range(0, 255)));
            endcase
            // The output side holds off while the input keeps coming, so the block backs up.
            if (p == 0)
                hold_request = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                choice = $urandom_range(0, 9);
                if (choice == 0)
                    line_noise();
                else if (mode_q[MODE_CANON])
                    canonical_line();
                else
                    raw_burst();
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
sv/tld_pkg.sv
sv/tld_ram.sv
sv/tld_front.sv
sv/tld_queue.sv
sv/tld_back.sv
sv/tty_line_discipline.sv
test/tty_line_discipline_test.sv
